// ===== sv/kms_pkg.sv =====
// Shared types and constants for the k-way merge with count summing.
package kms_pkg;

  localparam int unsigned KeyW    = 31;
  localparam int unsigned CntW    = 31;
  localparam int unsigned LaneW   = 4;
  localparam int unsigned MaskW   = 16;
  localparam int unsigned CfgW    = 5;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 80;

  // Register index (word address paddr[2])
  localparam logic RegLanesInUse = 1'b0;

  localparam logic [CfgW-1:0] LanesReset = 5'd16;

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic [CntW-1:0] cnt_t;

  // One refill request presented to the head store
  typedef struct packed {
    logic             en;
    logic [LaneW-1:0] lane;
    key_t             key;
    cnt_t             count;
    logic             is_end;
  } upd_t;

endpackage

// ===== sv/kms_heads.sv =====
// Lane head registers, ended flags and pending-refill mask.
module kms_heads #(
  parameter int unsigned LANE_CAP = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kms_pkg::upd_t        upd_i,
  input  logic                 restart_i,
  input  logic [LANE_CAP-1:0]  use_mask_i,
  input  logic [LANE_CAP-1:0]  next_mask_i,
  output kms_pkg::key_t        key_nx_o [LANE_CAP],
  output kms_pkg::cnt_t        cnt_nx_o [LANE_CAP],
  output logic [LANE_CAP-1:0]  live_nx_o,
  output logic                 fire_o
);
  import kms_pkg::*;

  key_t                head_key_q [LANE_CAP];
  cnt_t                head_cnt_q [LANE_CAP];
  logic [LANE_CAP-1:0] ended_q, ended_d;
  logic [LANE_CAP-1:0] pending_q, pending_d;
  logic [LANE_CAP-1:0] sel;
  logic                hit;

  always_comb begin
    for (int i = 0; i < LANE_CAP; i++) begin
      sel[i] = (upd_i.lane == LaneW'(i));
    end
  end

  // pending only ever holds lanes in use, so this also checks the lane range
  assign hit = upd_i.en && |(sel & pending_q);

  always_comb begin
    for (int i = 0; i < LANE_CAP; i++) begin
      if (hit && sel[i] && !upd_i.is_end) begin
        key_nx_o[i] = upd_i.key;
        cnt_nx_o[i] = upd_i.count;
      end else begin
        key_nx_o[i] = head_key_q[i];
        cnt_nx_o[i] = head_cnt_q[i];
      end
    end
  end

  always_comb begin
    ended_d = ended_q;
    if (hit && upd_i.is_end) begin
      ended_d = ended_q | sel;
    end
  end

  assign live_nx_o = use_mask_i & ~ended_d;
  assign fire_o    = hit && ((pending_q & ~sel) == '0);

  always_comb begin
    pending_d = pending_q;
    if (restart_i) begin
      pending_d = use_mask_i;
    end else if (fire_o) begin
      pending_d = next_mask_i;
    end else if (hit) begin
      pending_d = pending_q & ~sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q   <= '0;
      pending_q <= '1;
    end else begin
      ended_q   <= restart_i ? '0 : ended_d;
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANE_CAP; i++) begin
      if (hit && sel[i] && !upd_i.is_end) begin
        head_key_q[i] <= upd_i.key;
        head_cnt_q[i] <= upd_i.count;
      end
    end
  end

endmodule

// ===== sv/kms_reduce.sv =====
// Min-key tree, equal-key mask and saturating count-sum tree over lane heads.
module kms_reduce #(
  parameter int unsigned LANE_CAP = 16
) (
  input  kms_pkg::key_t       key_i [LANE_CAP],
  input  kms_pkg::cnt_t       cnt_i [LANE_CAP],
  input  logic [LANE_CAP-1:0] live_i,
  output logic                found_o,
  output kms_pkg::key_t       best_o,
  output kms_pkg::cnt_t       sum_o,
  output logic [LANE_CAP-1:0] mask_o
);
  import kms_pkg::*;

  localparam int unsigned LvlW  = (LANE_CAP > 1) ? $clog2(LANE_CAP) : 1;
  localparam int unsigned Leaves = 1 << LvlW;
  localparam int unsigned Nodes  = 2 * Leaves - 1;

  logic nv [Nodes];
  key_t nk [Nodes];
  cnt_t ns [Nodes];

  // heap layout: node k has children 2k+1 and 2k+2, leaves start at Leaves-1
  always_comb begin
    for (int i = 0; i < Leaves; i++) begin
      if (i < LANE_CAP) begin
        nv[Leaves-1+i] = live_i[i];
        nk[Leaves-1+i] = key_i[i];
      end else begin
        nv[Leaves-1+i] = 1'b0;
        nk[Leaves-1+i] = '0;
      end
    end
    for (int k = Leaves - 2; k >= 0; k--) begin
      if (nv[2*k+1] && (!nv[2*k+2] || nk[2*k+1] <= nk[2*k+2])) begin
        nv[k] = 1'b1;
        nk[k] = nk[2*k+1];
      end else begin
        nv[k] = nv[2*k+2];
        nk[k] = nk[2*k+2];
      end
    end
  end

  assign found_o = nv[0];
  assign best_o  = nk[0];

  always_comb begin
    for (int i = 0; i < LANE_CAP; i++) begin
      mask_o[i] = live_i[i] && (key_i[i] == nk[0]);
    end
  end

  // all terms are non-negative, so saturating per node equals saturating the total
  always_comb begin
    logic [CntW:0] s;
    for (int i = 0; i < Leaves; i++) begin
      if (i < LANE_CAP) begin
        ns[Leaves-1+i] = mask_o[i] ? cnt_i[i] : '0;
      end else begin
        ns[Leaves-1+i] = '0;
      end
    end
    for (int k = Leaves - 2; k >= 0; k--) begin
      s     = {1'b0, ns[2*k+1]} + {1'b0, ns[2*k+2]};
      ns[k] = s[CntW] ? '1 : s[CntW-1:0];
    end
  end

  assign sum_o = ns[0];

endmodule

// ===== sv/kway_merge_sum_counts_top.sv =====
// Top level: stream ports, config register, input and result registers.
// A request waits in the input register until the result register is free or being read.
// Throughput: one request per cycle while the result side is not stalled; the next-head update,
// min tree and count-sum tree all sit between the input register and the result register.
// Reset (rst_ni, async low): lanes_in_use = 16, no lane ended, all lanes in use pending.
// Head keys and counts have no reset; each lane head is refilled before it is compared.
module kway_merge_sum_counts_top #(
  parameter int unsigned NUM_LANES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // lane[3:0], key[34:4], count[65:35], zero pad
  input  logic [kms_pkg::InDataW-1:0]     s_axis_tdata_i,
  // is_end
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // merged_key[30:0], merged_count[61:31], refill_mask[77:62], zero pad
  output logic [kms_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // done_res
  output logic                            m_axis_tuser_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kms_pkg::AddrW-1:0]       paddr,
  input  logic [kms_pkg::ApbDataW-1:0]    pwdata,
  output logic [kms_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);
  import kms_pkg::*;

  localparam int unsigned LaneCap = (NUM_LANES < 16) ? NUM_LANES : 16;

  // config register
  logic [CfgW-1:0]    lanes_q, lanes_d;
  logic               cfg_wr;
  logic [CfgW-1:0]    n_act;
  logic [LaneCap-1:0] use_mask;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == RegLanesInUse);
  assign prdata  = (paddr[2] == RegLanesInUse) ? ApbDataW'(lanes_q) : '0;
  // restart takes the lane set of the value being written
  assign lanes_d = cfg_wr ? pwdata[CfgW-1:0] : lanes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q <= LanesReset;
    end else begin
      lanes_q <= lanes_d;
    end
  end

  always_comb begin
    if (lanes_d == '0) begin
      n_act = CfgW'(1);
    end else if (lanes_d > CfgW'(LaneCap)) begin
      n_act = CfgW'(LaneCap);
    end else begin
      n_act = lanes_d;
    end
    for (int i = 0; i < LaneCap; i++) begin
      use_mask[i] = (CfgW'(i) < n_act);
    end
  end

  // input register
  logic in_vld_q;
  upd_t in_q;
  logic go;
  logic in_acc;
  upd_t upd;

  assign go              = in_vld_q && (!m_axis_tvalid_o || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || go;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q.en     <= 1'b1;
      in_q.lane   <= s_axis_tdata_i[LaneW-1:0];
      in_q.key    <= s_axis_tdata_i[LaneW+KeyW-1:LaneW];
      in_q.count  <= s_axis_tdata_i[LaneW+KeyW+CntW-1:LaneW+KeyW];
      in_q.is_end <= s_axis_tuser_i;
    end
  end

  always_comb begin
    upd    = in_q;
    upd.en = go;
  end

  // head store and reduction
  key_t               key_nx [LaneCap];
  cnt_t               cnt_nx [LaneCap];
  logic [LaneCap-1:0] live_nx;
  logic [LaneCap-1:0] eq_mask;
  logic               fire;
  logic               found;
  key_t               best;
  cnt_t               sum;

  kms_heads #(
    .LANE_CAP(LaneCap)
  ) u_heads (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .restart_i  (cfg_wr),
    .use_mask_i (use_mask),
    .next_mask_i(eq_mask),
    .key_nx_o   (key_nx),
    .cnt_nx_o   (cnt_nx),
    .live_nx_o  (live_nx),
    .fire_o     (fire)
  );

  kms_reduce #(
    .LANE_CAP(LaneCap)
  ) u_reduce (
    .key_i  (key_nx),
    .cnt_i  (cnt_nx),
    .live_i (live_nx),
    .found_o(found),
    .best_o (best),
    .sum_o  (sum),
    .mask_o (eq_mask)
  );

  // result register
  logic                out_vld_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      // done result carries all-zero data
      out_done_q <= !found;
      if (found) begin
        out_data_q <= {(OutDataW - KeyW - CntW - MaskW)'(0), MaskW'(eq_mask), sum, best};
      end else begin
        out_data_q <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_done_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for kway_merge_sum_counts_top: directed table, then random merge runs.
module tb_top;
  import kms_pkg::*;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned RandItems    = 1400;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned MaxGap       = 18;
  localparam int unsigned MaxShown     = 10;
  localparam int unsigned ResetCycles  = 7;
  localparam longint      KeyHi        = 1073741823;
  localparam longint      KeyLo        = -1073741824;
  localparam cnt_t        CntMax       = '1;
  localparam logic        SpareRegIdx  = 1'b1;
  localparam logic [AddrW-1:0] LanesAddr = {RegLanesInUse, 2'b00};
  localparam logic [AddrW-1:0] SpareAddr = {SpareRegIdx, 2'b00};

  typedef struct packed {
    logic [LaneW-1:0] lane;
    key_t             key;
    cnt_t             count;
    logic             is_end;
  } req_t;

  typedef struct packed {
    key_t             key;
    cnt_t             count;
    logic [MaskW-1:0] mask;
    logic             done;
  } res_t;

  typedef enum logic [1:0] {RowItem, RowCfg, RowSpareCfg} row_kind_e;
  typedef enum logic [1:0] {ExpPredict, ExpNone, ExpTyped} exp_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    req_t            req;
    logic [CfgW-1:0] cfg;
    exp_kind_e       exp;
    res_t            res;
  } row_t;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                s_tready;
  logic                m_tvalid;
  logic                m_tready = 1'b1;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [AddrW-1:0]    paddr    = '0;
  logic [ApbDataW-1:0] pwdata   = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // merge predictor state
  logic [CfgW-1:0]  lanes_cfg;
  key_t             head_key [MaskW];
  cnt_t             head_cnt [MaskW];
  logic [MaskW-1:0] lane_done;
  logic [MaskW-1:0] pend_lanes;
  bit               all_ended;

  res_t        merged_q[$];
  int unsigned fail_cnt   = 0;
  int unsigned real_items = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned rx_hold    = 0;
  bit          tx_calm    = 1'b0;
  bit          rx_calm    = 1'b0;
  longint      last_key [MaskW];

  kway_merge_sum_counts_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned lanes_active();
    int unsigned n;
    n = 32'(lanes_cfg);
    if (n < 1) n = 1;
    if (n > MaskW) n = MaskW;
    return n;
  endfunction

  function automatic void restart_merge();
    logic [31:0] full;
    full = (32'd1 << lanes_active()) - 32'd1;
    lane_done  = '0;
    pend_lanes = full[MaskW-1:0];
    all_ended  = 1'b0;
  endfunction

  // One refill request: update the lane head, and once nothing is pending,
  // pick the smallest live key and sum the counts of every lane holding it.
  task automatic merge_step(input req_t rq, output bit taken, output bit hit, output res_t rs);
    int unsigned n;
    bit          found;
    key_t        best;
    logic [35:0] sum;
    logic [MaskW-1:0] mask;
    n     = lanes_active();
    taken = 1'b0;
    hit   = 1'b0;
    rs    = '0;
    found = 1'b0;
    best  = '0;
    sum   = '0;
    mask  = '0;
    if (rq.lane < n && pend_lanes[rq.lane]) begin
      taken = 1'b1;
      if (rq.is_end) begin
        lane_done[rq.lane] = 1'b1;
      end else begin
        head_key[rq.lane] = rq.key;
        head_cnt[rq.lane] = rq.count;
      end
      pend_lanes[rq.lane] = 1'b0;
      if (pend_lanes == '0) begin
        hit = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (!lane_done[i] && (!found || head_key[i] < best)) begin
            best  = head_key[i];
            found = 1'b1;
          end
        end
        if (!found) begin
          rs.done   = 1'b1;
          all_ended = 1'b1;
        end else begin
          for (int i = 0; i < n; i++) begin
            if (!lane_done[i] && head_key[i] == best) begin
              sum     = sum + 36'(head_cnt[i]);
              mask[i] = 1'b1;
            end
          end
          rs.key     = best;
          rs.count   = (sum > {5'b0, CntMax}) ? CntMax : sum[CntW-1:0];
          rs.mask    = mask;
          pend_lanes = mask;
        end
      end
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    fail_cnt++;
    if (fail_cnt <= MaxShown)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  function automatic int unsigned sender_gap();
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    return tx_calm ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic cnt_t draw_count();
    case ($urandom_range(0, 15))
      0:       return CntMax;
      1, 2, 3: return cnt_t'($urandom);
      default: return cnt_t'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic res_t res_of(input longint key, input longint cnt,
                                  input logic [MaskW-1:0] mask, input logic done);
    res_t r;
    r.key   = key_t'(key);
    r.count = cnt_t'(cnt);
    r.mask  = mask;
    r.done  = done;
    return r;
  endfunction

  function automatic row_t item_row(input int unsigned lane, input longint key,
                                    input longint cnt, input logic is_end,
                                    input exp_kind_e exp, input res_t res);
    row_t r;
    r          = '0;
    r.kind     = RowItem;
    r.req.lane = LaneW'(lane);
    r.req.key  = key_t'(key);
    r.req.count = cnt_t'(cnt);
    r.req.is_end = is_end;
    r.exp      = exp;
    r.res      = res;
    return r;
  endfunction

  function automatic row_t cfg_row(input row_kind_e kind, input int unsigned val);
    row_t r;
    r      = '0;
    r.kind = kind;
    r.cfg  = CfgW'(val);
    r.exp  = ExpNone;
    return r;
  endfunction

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [CfgW-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LanesAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(ApbDataW-CfgW){1'b0}}, want})
      note_mismatch("lanes_in_use readback", {{(ApbDataW-CfgW){1'b0}}, want}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // drain outstanding results and give silent requests time to retire
  task automatic settle_merge();
    s_tvalid <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_reg(input logic [AddrW-1:0] addr, input logic [ApbDataW-1:0] data);
    settle_merge();
    apb_write(addr, data);
    if (addr == LanesAddr) begin
      lanes_cfg = data[CfgW-1:0];
      restart_merge();
    end
    @(posedge clk_i);
    apb_read_check(lanes_cfg);
  endtask

  task automatic send_item(input req_t rq, input exp_kind_e exp, input res_t typed);
    int unsigned gap;
    bit          taken;
    bit          hit;
    res_t        rs;
    gap = sender_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataW-LaneW-KeyW-CntW){1'b0}}, rq.count, rq.key, rq.lane};
    s_tuser  <= rq.is_end;
    do @(posedge clk_i); while (!s_tready);
    merge_step(rq, taken, hit, rs);
    if (taken) real_items++;
    case (exp)
      ExpTyped:   merged_q.push_back(typed);
      ExpPredict: if (hit) merged_q.push_back(rs);
      default:    ;
    endcase
  endtask

  // result side: check against the oldest expectation, then draw the next stall
  always @(posedge clk_i) begin : result_check
    res_t        got;
    res_t        want;
    int unsigned hold;
    if (rst_ni && m_tvalid && m_tready) begin
      got.key   = m_tdata[KeyW-1:0];
      got.count = m_tdata[KeyW+CntW-1:KeyW];
      got.mask  = m_tdata[KeyW+CntW+MaskW-1:KeyW+CntW];
      got.done  = m_tuser;
      if (merged_q.size() == 0) begin
        note_mismatch("result with none expected, key", '0, 32'(got.key));
      end else begin
        want = merged_q.pop_front();
        if (got.key !== want.key)
          note_mismatch("merged_key", 32'(want.key), 32'(got.key));
        if (got.count !== want.count)
          note_mismatch("merged_count", 32'(want.count), 32'(got.count));
        if (got.mask !== want.mask)
          note_mismatch("refill_mask", 32'(want.mask), 32'(got.mask));
        if (got.done !== want.done)
          note_mismatch("done_res", 32'(want.done), 32'(got.done));
      end
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      hold = rx_calm ? 0 : $urandom_range(0, MaxGap);
      rx_hold  <= hold;
      m_tready <= (hold == 0);
    end else if (rx_hold != 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= (rx_hold == 1);
    end
  end

  initial begin : stimulus
    row_t        rows[$];
    req_t        rq;
    int          pick;
    int unsigned lane_sel;
    int unsigned budget;
    int unsigned extra;
    int unsigned v;
    longint      nk;
    longint      base;
    logic [ApbDataW-1:0] wdata;

    // directed table: two lanes, then one, then three
    rows.push_back(cfg_row(RowCfg, 2));
    rows.push_back(item_row(0, KeyLo, CntMax, 1'b0, ExpNone, '0));
    rows.push_back(item_row(1, KeyLo, 1, 1'b0, ExpTyped, res_of(KeyLo, CntMax, 16'h3, 1'b0)));
    rows.push_back(item_row(3, 0, 0, 1'b0, ExpNone, '0));       // lane not in use
    rows.push_back(item_row(0, KeyHi, 5, 1'b0, ExpNone, '0));
    rows.push_back(item_row(0, 9, 9, 1'b0, ExpNone, '0));       // lane not pending
    rows.push_back(item_row(1, 7, 0, 1'b0, ExpTyped, res_of(7, 0, 16'h2, 1'b0)));
    rows.push_back(cfg_row(RowSpareCfg, 1));                     // unmapped register
    rows.push_back(item_row(1, 0, 0, 1'b1, ExpTyped, res_of(KeyHi, 5, 16'h1, 1'b0)));
    rows.push_back(item_row(0, 0, 0, 1'b1, ExpTyped, res_of(0, 0, 16'h0, 1'b1)));
    rows.push_back(item_row(0, 1, 1, 1'b0, ExpNone, '0));       // after done
    rows.push_back(cfg_row(RowCfg, 0));                          // zero means one lane
    rows.push_back(item_row(15, 3, 3, 1'b0, ExpNone, '0));
    rows.push_back(item_row(0, 0, 0, 1'b0, ExpTyped, res_of(0, 0, 16'h1, 1'b0)));
    rows.push_back(item_row(0, 0, 0, 1'b1, ExpTyped, res_of(0, 0, 16'h0, 1'b1)));
    rows.push_back(cfg_row(RowCfg, 3));
    rows.push_back(item_row(0, 5, 10, 1'b0, ExpNone, '0));
    rows.push_back(item_row(2, 5, 20, 1'b0, ExpNone, '0));
    rows.push_back(item_row(1, 0, 0, 1'b1, ExpTyped, res_of(5, 30, 16'h5, 1'b0)));
    rows.push_back(item_row(2, -1, 32'h7FFF_FFFE, 1'b0, ExpNone, '0));
    rows.push_back(item_row(0, 6, 2, 1'b0, ExpPredict, '0));
    rows.push_back(item_row(2, 0, 0, 1'b1, ExpPredict, '0));
    rows.push_back(item_row(0, 0, 0, 1'b1, ExpTyped, res_of(0, 0, 16'h0, 1'b1)));

    lanes_cfg = LanesReset;
    restart_merge();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_read_check(LanesReset);

    foreach (rows[k]) begin
      case (rows[k].kind)
        RowCfg:      program_reg(LanesAddr, {{(ApbDataW-CfgW){1'b0}}, rows[k].cfg});
        RowSpareCfg: program_reg(SpareAddr, {{(ApbDataW-CfgW){1'b0}}, rows[k].cfg});
        default:     send_item(rows[k].req, rows[k].exp, rows[k].res);
      endcase
    end

    // random merge runs, each under a fresh lane count
    while (real_items < RandItems) begin
      case ($urandom_range(0, 7))
        0:       v = 0;
        1:       v = 1;
        2:       v = 2;
        3:       v = 16;
        4:       v = $urandom_range(17, 31);
        default: v = $urandom_range(1, 16);
      endcase
      wdata = $urandom_range(0, 1) ? (($urandom & ~32'h1F) | v) : v;
      program_reg(LanesAddr, wdata);

      case ($urandom_range(0, 5))
        0:       base = KeyLo;
        1:       base = KeyHi - $urandom_range(0, 40);
        default: base = longint'(key_t'($urandom));
      endcase
      for (int i = 0; i < MaskW; i++) begin
        last_key[i] = base + $urandom_range(0, 3);
        if (last_key[i] > KeyHi) last_key[i] = KeyHi;
      end

      budget = $urandom_range(20, 400);
      while (budget != 0 && !all_ended && real_items < RandItems) begin
        budget--;
        if ($urandom_range(0, 7) == 0) begin
          // noise: any lane, any content
          rq.lane   = LaneW'($urandom_range(0, 15));
          rq.key    = key_t'($urandom);
          rq.count  = cnt_t'($urandom);
          rq.is_end = ($urandom_range(0, 7) == 0);
        end else begin
          pick     = $urandom_range(0, $countones(pend_lanes) - 1);
          lane_sel = 0;
          for (int i = 0; i < MaskW; i++) begin
            if (pend_lanes[i]) begin
              if (pick == 0) lane_sel = i;
              pick--;
            end
          end
          rq.lane   = LaneW'(lane_sel);
          rq.is_end = ($urandom_range(0, 9) == 0);
          if (rq.is_end) begin
            rq.key   = key_t'($urandom);
            rq.count = cnt_t'($urandom);
          end else begin
            // small steps keep keys colliding across lanes
            case ($urandom_range(0, 9))
              0, 1, 2, 3: nk = last_key[lane_sel];
              4, 5, 6, 7: nk = last_key[lane_sel] + $urandom_range(1, 3);
              8:          nk = last_key[lane_sel] + $urandom_range(4, 1000);
              default:    nk = last_key[lane_sel] + $urandom_range(0, 1 << 22);
            endcase
            if (nk > KeyHi) nk = KeyHi;
            last_key[lane_sel] = nk;
            rq.key   = key_t'(nk);
            rq.count = draw_count();
          end
        end
        send_item(rq, ExpPredict, '0);
      end

      if (all_ended) begin
        extra = $urandom_range(0, 2);
        repeat (extra) begin
          rq.lane   = LaneW'($urandom_range(0, 15));
          rq.key    = key_t'($urandom);
          rq.count  = cnt_t'($urandom);
          rq.is_end = 1'($urandom_range(0, 1));
          send_item(rq, ExpPredict, '0);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && merged_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
